// ===== hw/rtl/degree_sine_cosine_unit_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the degree sine/cosine unit
// Each macro checks one implication on the rising edge of clk, with the
// check held off while rst_n is low. Defining ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef DEGREE_SINE_COSINE_UNIT_TOP_ASSERT_SVH
`define DEGREE_SINE_COSINE_UNIT_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define SDC_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define SDC_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define SDC_ASSERT_NOW(label, cond, expr, msg)
`define SDC_ASSERT_NEXT(label, cond, expr, msg)
`endif
`endif

// ===== hw/rtl/sdc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared constants, types and table-building functions of the degree
// sine/cosine unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdc_pkg;

    // Internal fixed-point format of the series evaluation: unsigned Q2.30.
    localparam int WORK_BITS = 30;
    // Pi scaled by 2^30, rounded.
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // Defaults of the top-level parameters.
    localparam int TERMS_DEFAULT     = 10;
    localparam int FRAC_BITS_DEFAULT = 14;

    // Port widths.
    localparam int ANGLE_W = 16;
    localparam int VALUE_W = 16;

    // Angle reduction: the angle is biased by a multiple of a full turn so it
    // is never negative, then divided by 360 through a reciprocal multiply.
    localparam int BIASED_W    = 17;
    localparam int PROD_W      = 2 * BIASED_W;
    localparam int RECIP_SHIFT = 25;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic [BIASED_W-1:0]   RECIP_360 = 17'd93207;
    localparam logic signed [BIASED_W:0] TURN_BIAS = 18'sd33120;

    // Reduced angle 0..359 and folded first-quadrant angle 0..90.
    localparam int TURN_W      = 9;
    localparam int DEG_W       = 7;
    localparam int QUARTER_DEG = 90;
    localparam logic [TURN_W-1:0] FULL_TURN     = 9'd360;
    localparam logic [TURN_W-1:0] THREE_QUARTER = 9'd270;
    localparam logic [TURN_W-1:0] HALF_TURN     = 9'd180;
    localparam logic [TURN_W-1:0] QUARTER_TURN  = 9'd90;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Width used to apply the quadrant sign before masking to the port width.
    localparam int MAG_CALC_W = 32;

    // One classified angle: folded degrees and the two quadrant signs.
    typedef struct packed {
        logic [DEG_W-1:0] deg;
        logic             cos_neg;
        logic             sin_neg;
    } sdc_item_t;

    // Head of the queue as seen by the back part.
    typedef struct packed {
        logic      valid;
        sdc_item_t item;
    } sdc_head_t;

    // Rounded Q2.30 product.
    function automatic logic [63:0] sdc_qmul(input logic [63:0] p, input logic [63:0] q);
        return (p * q + (64'd1 << (WORK_BITS - 1))) >> WORK_BITS;
    endfunction

    // Unsigned quotient by shift and subtract, one bit per step.
    function automatic logic [63:0] sdc_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        int          b;
        quo = '0;
        rem = '0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Magnitude of cosine (odd = 0) or sine (odd = 1) of a first-quadrant
    // angle in whole degrees, rounded and saturated to frac_bits fraction
    // bits. Evaluated only while building the constant tables.
    function automatic logic [63:0] sdc_series_mag(input int deg, input bit odd,
                                                   input int terms, input int frac_bits);
        logic [63:0]        r;
        logic [63:0]        r2;
        logic [63:0]        t;
        logic [63:0]        nn;
        logic [63:0]        v;
        logic [63:0]        one;
        logic signed [63:0] sum;
        int                 n;
        int                 k;
        int                 sh;
        one = 64'd1 << frac_bits;
        // A right angle is exact: cosine zero, sine one.
        if (deg == QUARTER_DEG)
        begin
            return odd ? one : 64'd0;
        end
        r   = sdc_udiv(64'(deg) * PI_Q30 + 64'd90, 64'd180);
        r2  = sdc_qmul(r, r);
        t   = odd ? r : (64'd1 << WORK_BITS);
        sum = signed'(t);
        for (k = 1; k < terms; k++)
        begin
            n  = odd ? (2 * k) : (2 * k - 1);
            nn = 64'(n * (n + 1));
            t  = sdc_udiv(sdc_qmul(t, r2) + (nn >> 1), nn);
            if ((k & 1) == 1)
            begin
                sum = sum - signed'(t);
            end
            else
            begin
                sum = sum + signed'(t);
            end
        end
        // Clamp to 0..1, round to the output fraction and saturate at one.
        sh = WORK_BITS - frac_bits;
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        if (sum > signed'(64'd1 << WORK_BITS))
        begin
            sum = signed'(64'd1 << WORK_BITS);
        end
        v = unsigned'(sum);
        if (sh > 0)
        begin
            v = (v + (64'd1 << (sh - 1))) >> sh;
        end
        if (v > one)
        begin
            v = one;
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/sdc_front.sv =====
// ----------------------------------------------------------------------------
// sdc_front
// Accepts angles, reduces them modulo 360 and folds them into the first
// quadrant with the signs of cosine and sine. Writes one item per angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdc_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [sdc_pkg::ANGLE_W-1:0]  angle_degrees,
    input  logic        [sdc_pkg::QCNT_W-1:0]   queue_count,
    output logic                                item_push,
    output sdc_pkg::sdc_item_t                  item
);
    import sdc_pkg::*;

    logic                       stage_valid_reg;
    logic                       stage_valid_next;
    logic [BIASED_W-1:0]        biased_reg;
    logic [BIASED_W-1:0]        biased_next;
    logic [PROD_W-1:0]          prod_reg;
    logic [PROD_W-1:0]          prod_next;
    logic signed [BIASED_W:0]   biased_wide;
    logic [QCNT_W:0]            occupancy;
    logic                       accept;
    logic [QUOT_W-1:0]          quot;
    logic [BIASED_W-1:0]        turn_rem;
    logic [TURN_W-1:0]          turn;
    logic [TURN_W-1:0]          fold;

    // Room is counted over the queue and the item in the multiply stage.
    assign occupancy = {1'b0, queue_count} + (QCNT_W + 1)'(stage_valid_reg);
    assign full      = (occupancy >= (QCNT_W + 1)'(QUEUE_DEPTH));
    assign accept    = push && !full;

    // Bias to a non-negative value and start the divide by 360.
    assign biased_wide      = (BIASED_W + 1)'(angle_degrees) + TURN_BIAS;
    assign biased_next      = biased_wide[BIASED_W-1:0];
    assign prod_next        = PROD_W'(biased_next) * PROD_W'(RECIP_360);
    assign stage_valid_next = accept;

    // Stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Stage payload, loaded on each input transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            biased_reg <= biased_next;
            prod_reg   <= prod_next;
        end
    end

    // The reciprocal is exact over the biased range, so the quotient needs
    // no correction and the remainder is the angle in 0..359.
    assign quot     = prod_reg[PROD_W-1 -: QUOT_W];
    assign turn_rem = biased_reg - BIASED_W'(quot) * BIASED_W'(FULL_TURN);
    assign turn     = turn_rem[TURN_W-1:0];

    // Fold into the first quadrant. Multiples of 90 land on 0 or 90.
    always_comb
    begin
        priority if (turn < QUARTER_TURN)
        begin
            fold         = turn;
            item.cos_neg = 1'b0;
            item.sin_neg = 1'b1;
        end
        else if (turn < HALF_TURN)
        begin
            fold         = HALF_TURN - turn;
            item.cos_neg = 1'b1;
            item.sin_neg = 1'b1;
        end
        else if (turn < THREE_QUARTER)
        begin
            fold         = turn - HALF_TURN;
            item.cos_neg = 1'b1;
            item.sin_neg = 1'b0;
        end
        else
        begin
            fold         = FULL_TURN - turn;
            item.cos_neg = 1'b0;
            item.sin_neg = 1'b0;
        end
        item.deg = fold[DEG_W-1:0];
    end

    assign item_push = stage_valid_reg;

endmodule

// ===== hw/rtl/sdc_queue.sv =====
// ----------------------------------------------------------------------------
// sdc_queue
// Short first-in first-out queue of classified angles between the front
// and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdc_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_push,
    input  sdc_pkg::sdc_item_t              item,
    input  logic                            item_pop,
    output sdc_pkg::sdc_head_t              head,
    output logic [sdc_pkg::QCNT_W-1:0]      count
);
    import sdc_pkg::*;

    sdc_item_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (item_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (item_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({item_push, item_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (item_push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

// ===== hw/rtl/sdc_back.sv =====
// ----------------------------------------------------------------------------
// sdc_back
// Looks up cosine and sine magnitudes of the folded angle, applies the
// quadrant signs and holds the result in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdc_back #(
    parameter int TERMS     = sdc_pkg::TERMS_DEFAULT,
    parameter int FRAC_BITS = sdc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sdc_pkg::sdc_head_t                  head,
    output logic                                item_pop,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [sdc_pkg::VALUE_W-1:0]  cosine_value,
    output logic signed [sdc_pkg::VALUE_W-1:0]  neg_sine_value
);
    import sdc_pkg::*;

    localparam int MAG_W = FRAC_BITS + 1;

    logic [MAG_W-1:0]       cos_rom [QUARTER_DEG + 1];
    logic [MAG_W-1:0]       sin_rom [QUARTER_DEG + 1];
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [VALUE_W-1:0]     cos_reg;
    logic [VALUE_W-1:0]     cos_next;
    logic [VALUE_W-1:0]     sin_reg;
    logic [VALUE_W-1:0]     sin_next;
    logic [MAG_CALC_W-1:0]  cos_mag;
    logic [MAG_CALC_W-1:0]  sin_mag;
    logic [MAG_CALC_W-1:0]  cos_signed;
    logic [MAG_CALC_W-1:0]  sin_signed;
    logic                   load;

    // Constant tables of the series, one entry per whole degree 0..90.
    for (genvar g = 0; g <= QUARTER_DEG; g++)
    begin : g_rom
        localparam logic [63:0] COS_ENTRY = sdc_series_mag(g, 1'b0, TERMS, FRAC_BITS);
        localparam logic [63:0] SIN_ENTRY = sdc_series_mag(g, 1'b1, TERMS, FRAC_BITS);
        assign cos_rom[g] = COS_ENTRY[MAG_W-1:0];
        assign sin_rom[g] = SIN_ENTRY[MAG_W-1:0];
    end

    // Take the head item whenever the output register is free or drained.
    assign load     = head.valid && (!out_valid_reg || pop);
    assign item_pop = load;

    // Apply the quadrant signs and mask to the port width.
    assign cos_mag    = MAG_CALC_W'(cos_rom[head.item.deg]);
    assign sin_mag    = MAG_CALC_W'(sin_rom[head.item.deg]);
    assign cos_signed = head.item.cos_neg ? (~cos_mag + 1'b1) : cos_mag;
    assign sin_signed = head.item.sin_neg ? (~sin_mag + 1'b1) : sin_mag;
    assign cos_next   = cos_signed[VALUE_W-1:0];
    assign sin_next   = sin_signed[VALUE_W-1:0];

    // Output valid flag.
    always_comb
    begin
        priority if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign empty          = !out_valid_reg;
    assign cosine_value   = signed'(cos_reg);
    assign neg_sine_value = signed'(sin_reg);

endmodule

// ===== hw/rtl/degree_sine_cosine_unit_top.sv =====
// A result is registered in the multiply stage, then the queue, then the output register.
// Throughput: one angle per cycle while pop drains the output register; the
// multiply stage, four-entry queue and output register each move one item per cycle.
// The front stalls only when the queue and its multiply stage hold four items.
// Reset clears the valid flags and queue pointers; no angle or result survives it.
// ----------------------------------------------------------------------------
// degree_sine_cosine_unit_top
// Cosine and negated sine in signed fixed point of a whole-degree angle,
// with a front part for reduction, a queue, and a back part for lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "degree_sine_cosine_unit_top_assert.svh"

module degree_sine_cosine_unit_top #(
    parameter int TERMS     = sdc_pkg::TERMS_DEFAULT,
    parameter int FRAC_BITS = sdc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [sdc_pkg::ANGLE_W-1:0]  angle_degrees,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [sdc_pkg::VALUE_W-1:0]  cosine_value,
    output logic signed [sdc_pkg::VALUE_W-1:0]  neg_sine_value
);
    import sdc_pkg::*;

    logic               item_push;
    sdc_item_t          item;
    logic               item_pop;
    sdc_head_t          q_head;
    logic [QCNT_W-1:0]  q_count;

    // Front: reduction and quadrant folding.
    sdc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .angle_degrees (angle_degrees),
        .queue_count   (q_count),
        .item_push     (item_push),
        .item          (item)
    );

    // Queue between the two parts.
    sdc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_push (item_push),
        .item      (item),
        .item_pop  (item_pop),
        .head      (q_head),
        .count     (q_count)
    );

    // Back: table lookup, sign and output register.
    sdc_back #(
        .TERMS     (TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (q_head),
        .item_pop       (item_pop),
        .empty          (empty),
        .pop            (pop),
        .cosine_value   (cosine_value),
        .neg_sine_value (neg_sine_value)
    );

    // Queue occupancy never passes its depth.
    `SDC_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= QCNT_W'(QUEUE_DEPTH), "queue overflow")
    // A full queue receives no item in the following cycle.
    `SDC_ASSERT_NEXT(a_no_push_when_full, q_count == QCNT_W'(QUEUE_DEPTH), !item_push, "push into full queue")
    // The back part drains the queue only into a free output register.
    `SDC_ASSERT_NOW(a_pop_into_room, item_pop, empty || pop, "result overwritten")
    // The back part never drains an empty queue.
    `SDC_ASSERT_NOW(a_pop_has_item, item_pop, q_head.valid, "pop from empty queue")

endmodule
